/* sv/cfd_pkg.sv */
// Shared types and codes for the checksummed frame deframer.
// Used by the interfaces, the frame parser, the output buffer and the top level.
package cfd_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 3;

  // Final status codes.
  localparam logic [StatusW-1:0] STATUS_OK       = 3'd0;
  localparam logic [StatusW-1:0] STATUS_LCS_BAD  = 3'd1;
  localparam logic [StatusW-1:0] STATUS_ID_BAD   = 3'd2;
  localparam logic [StatusW-1:0] STATUS_TOO_LONG = 3'd3;
  localparam logic [StatusW-1:0] STATUS_DCS_BAD  = 3'd4;

  // Reset value of the expected frame id register.
  localparam logic [ByteW-1:0] FRAME_ID_RESET = 8'd213;

  // One result item.
  typedef struct packed {
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic               last;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   payload_count;
  } cfd_result_t;

endpackage

/* sv/cfd_if.sv */
// Valid/ready channel interfaces for the deframer input bytes and its results.
// Depends on cfd_pkg for field widths.
interface cfd_in_if;
  import cfd_pkg::*;

  logic             valid;
  logic             ready;
  logic             start_frame;
  logic [ByteW-1:0] rx_byte;
  logic [ByteW-1:0] payload_limit;

  modport source (output valid, output start_frame, output rx_byte,
                  output payload_limit, input ready);
  modport sink (input valid, input start_frame, input rx_byte,
                input payload_limit, output ready);
endinterface

interface cfd_out_if;
  import cfd_pkg::*;

  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [ByteW-1:0]   payload_byte;
  logic               last;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   payload_count;

  modport source (output valid, output payload_valid, output payload_byte,
                  output last, output status, output payload_count, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input last, input status, input payload_count, output ready);
endinterface

/* sv/cfd_parser.sv */
// Frame parser: header skip, length and id checks, payload forwarding, data check.
// Depends on cfd_pkg for the result type and status codes.
module cfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          start_frame,
  input  logic [cfd_pkg::ByteW-1:0]     rx_byte,
  input  logic [cfd_pkg::ByteW-1:0]     payload_limit,
  input  logic [cfd_pkg::ByteW-1:0]     expected_frame_id,
  output logic                          has_result,
  output cfd_pkg::cfd_result_t          result
);
  import cfd_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_LCS    = 3'd3;
  localparam logic [2:0] PH_ID     = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_DCS    = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [1:0]       header_skip_count, header_skip_count_next;
  logic [ByteW-1:0] length_byte, length_byte_next;
  logic [ByteW-1:0] bytes_remaining, bytes_remaining_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [ByteW-1:0] limit_held, limit_held_next;
  logic [ByteW-1:0] len_minus_one;

  assign len_minus_one = length_byte - 8'd1;

  // Next state and the result caused by the byte on the input.
  always_comb begin
    phase_next             = phase;
    header_skip_count_next = header_skip_count;
    length_byte_next       = length_byte;
    bytes_remaining_next   = bytes_remaining;
    running_sum_next       = running_sum;
    limit_held_next        = limit_held;
    has_result             = 1'b0;
    result                 = '0;

    if (start_frame) begin
      limit_held_next        = payload_limit;
      header_skip_count_next = 2'd1;
      phase_next             = PH_HEADER;
    end else begin
      case (phase)
        PH_HEADER: begin
          header_skip_count_next = header_skip_count + 2'd1;
          if (header_skip_count_next == 2'd3) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          length_byte_next = rx_byte;
          phase_next       = PH_LCS;
        end
        PH_LCS: begin
          if (length_byte + rx_byte != 8'd0) begin
            has_result    = 1'b1;
            result.last   = 1'b1;
            result.status = STATUS_LCS_BAD;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_ID;
          end
        end
        PH_ID: begin
          bytes_remaining_next = len_minus_one;
          running_sum_next     = expected_frame_id;
          if (rx_byte != expected_frame_id) begin
            has_result    = 1'b1;
            result.last   = 1'b1;
            result.status = STATUS_ID_BAD;
            phase_next    = PH_IDLE;
          end else if (len_minus_one > limit_held) begin
            has_result    = 1'b1;
            result.last   = 1'b1;
            result.status = STATUS_TOO_LONG;
            phase_next    = PH_IDLE;
          end else if (len_minus_one == 8'd0) begin
            phase_next = PH_DCS;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum_next     = running_sum + rx_byte;
          bytes_remaining_next = bytes_remaining - 8'd1;
          if (bytes_remaining_next == 8'd0) begin
            phase_next = PH_DCS;
          end
          has_result           = 1'b1;
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
        end
        PH_DCS: begin
          has_result  = 1'b1;
          result.last = 1'b1;
          phase_next  = PH_IDLE;
          if (running_sum + rx_byte != 8'd0) begin
            result.status = STATUS_DCS_BAD;
          end else begin
            result.status        = STATUS_OK;
            result.payload_count = len_minus_one;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State registers advance only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      header_skip_count <= 2'd0;
      length_byte       <= '0;
      bytes_remaining   <= '0;
      running_sum       <= '0;
      limit_held        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      header_skip_count <= header_skip_count_next;
      length_byte       <= length_byte_next;
      bytes_remaining   <= bytes_remaining_next;
      running_sum       <= running_sum_next;
      limit_held        <= limit_held_next;
    end
  end

  // A final result always leaves the parser idle.
  assert property (@(posedge clk) disable iff (rst)
    accept && has_result && result.last |=> phase == PH_IDLE)
    else $error("parser not idle after final result");

  // A start byte never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    start_frame |-> !has_result)
    else $error("result on start byte");

  // Payload results come only from the data phase.
  assert property (@(posedge clk) disable iff (rst)
    has_result && result.payload_valid |-> phase == PH_DATA && !result.last)
    else $error("payload result outside data phase");

  // An ok status is given only after a data check byte.
  assert property (@(posedge clk) disable iff (rst)
    has_result && result.last && result.status == STATUS_OK |-> phase == PH_DCS)
    else $error("ok status outside data check phase");

endmodule

/* sv/cfd_out_buf.sv */
// Two-entry output buffer: a result register plus a skid register.
// Depends on cfd_pkg for the result type.
module cfd_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfd_pkg::cfd_result_t push_data,
  output logic                 can_accept,
  output logic                 out_valid,
  output cfd_pkg::cfd_result_t out_data,
  input  logic                 out_ready
);
  import cfd_pkg::*;

  logic        skid_valid;
  cfd_result_t skid_data;

  // New transfers are taken as long as the skid register is free.
  assign can_accept = !skid_valid;

  // Control: the result register drains first, the skid register refills it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload moves with the control above.
  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (out_valid && out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // The skid register is only occupied behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without result entry");

  // The skid register fills only when the result register was stalled.
  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stall");

  // Draining the skid entry keeps a result on the output.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid entry lost while draining");

endmodule

/* sv/checksummed_frame_deframer_top.sv */
// Top level of the checksummed frame deframer.
// Depends on cfd_pkg, cfd_if, cfd_parser and cfd_out_buf.
//
// The deframer takes one received byte per transfer and can take a new byte in
// every clock cycle: each byte is checked and added in a single pass of logic
// and its result, if any, is written into a two-entry output buffer, so input
// transfers continue while one result waits for the consumer. Payload bytes are
// passed on as they arrive, before the data check is known; a consumer must
// drop the bytes of a frame whose final result has a status other than ok.
// The input stalls only when both output buffer entries are full. The expected
// frame id register should be written only while no frame is in progress.
module checksummed_frame_deframer_top #(
  parameter logic [cfd_pkg::ByteW-1:0] FrameIdReset = cfd_pkg::FRAME_ID_RESET
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [cfd_pkg::ByteW-1:0] cfg_wr_data,
  cfd_in_if.sink                    rx_ch,
  cfd_out_if.source                 res_ch
);
  import cfd_pkg::*;

  logic [ByteW-1:0] frame_id;
  logic             accept;
  logic             has_result;
  logic             can_accept;
  cfd_result_t      result;
  cfd_result_t      out_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id <= FrameIdReset;
    end else if (cfg_wr_en) begin
      frame_id <= cfg_wr_data;
    end
  end

  // Input handshake.
  assign rx_ch.ready = can_accept;
  assign accept      = rx_ch.valid && rx_ch.ready;

  cfd_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .start_frame       (rx_ch.start_frame),
    .rx_byte           (rx_ch.rx_byte),
    .payload_limit     (rx_ch.payload_limit),
    .expected_frame_id (frame_id),
    .has_result        (has_result),
    .result            (result)
  );

  cfd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && has_result),
    .push_data  (result),
    .can_accept (can_accept),
    .out_valid  (res_ch.valid),
    .out_data   (out_data),
    .out_ready  (res_ch.ready)
  );

  // Result fields onto the output channel.
  assign res_ch.payload_valid = out_data.payload_valid;
  assign res_ch.payload_byte  = out_data.payload_byte;
  assign res_ch.last          = out_data.last;
  assign res_ch.status        = out_data.status;
  assign res_ch.payload_count = out_data.payload_count;

endmodule
